// ----- rtl/sarr_pkg.sv -----
// Shared types and constants for the shifting array core.
// No dependencies; used by sarr_cell and shifting_array_insert_delete_core.
`timescale 1ns / 1ps

package sarr_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int POS_BITS      = 4;
  localparam int IN_WORD_BITS  = 32;
  localparam int COUNT_BITS    = 5;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_APPEND = 3'd1,
    FN_DELETE = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic ins;
    logic app;
    logic del;
  } cell_ctrl_t;

endpackage

// ----- rtl/sarr_cell.sv -----
// One slot of the shifting array: holds a word, loads it from either neighbour or the input.
// Depends on sarr_pkg (cell_ctrl_t).
`timescale 1ns / 1ps

module sarr_cell #(
  parameter int WORD_BITS = sarr_pkg::WORD_BITS_DEF,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  sarr_pkg::cell_ctrl_t  ctrl,
  input  logic [CNT_W-1:0]      pos,
  input  logic [CNT_W-1:0]      count,
  input  logic [WORD_BITS-1:0]  lo_d,
  input  logic [WORD_BITS-1:0]  hi_d,
  input  logic [WORD_BITS-1:0]  val,
  output logic [WORD_BITS-1:0]  q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [WORD_BITS-1:0] d_r;
  logic [WORD_BITS-1:0] d_nxt;

  always_comb begin
    d_nxt = d_r;
    if ((ctrl.ins && MY_IDX == pos) || (ctrl.app && MY_IDX == count)) begin
      d_nxt = val;
    end else if (ctrl.ins && MY_IDX > pos) begin
      d_nxt = lo_d;
    end else if (ctrl.del && MY_IDX >= pos) begin
      d_nxt = hi_d;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign q = d_r;

endmodule

// ----- rtl/shifting_array_insert_delete_core.sv -----
// Shifting array core: ordered array of signed words with insert, append, delete,
// clear and read. Depends on sarr_pkg and sarr_cell.
// out_valid is a registered result strobe, raised in the cycle after the word is accepted.
// Throughput: one word per cycle while busy is low; the cells past the insert or delete position shift together.
// busy is high only while rst_n is low and the cycle after; reset empties the array.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module shifting_array_insert_delete_core #(
  parameter int DEPTH     = sarr_pkg::DEPTH_DEF,
  parameter int WORD_BITS = sarr_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_func,
  input  logic [sarr_pkg::POS_BITS-1:0]       in_position,
  input  logic signed [sarr_pkg::IN_WORD_BITS-1:0] in_value_in,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [sarr_pkg::COUNT_BITS-1:0]     out_count_out,
  output logic signed [sarr_pkg::IN_WORD_BITS-1:0] out_value_out
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > sarr_pkg::POS_BITS) ? CNT_W : sarr_pkg::POS_BITS;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                       busy_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       out_valid_r;
  sarr_pkg::status_t          out_status_r, status_nxt;
  logic [sarr_pkg::COUNT_BITS-1:0]   out_count_r;
  logic [sarr_pkg::IN_WORD_BITS-1:0] out_value_r, rd_nxt;

  logic                       acc;
  logic                       is_empty, is_full, pos_ok;
  sarr_pkg::cell_ctrl_t       ctrl;
  logic [CNT_W-1:0]           cell_pos;
  logic [63:0]                val64, rd64;
  logic [WORD_BITS-1:0]       val_w, rd_word;
  logic [WORD_BITS-1:0]       cell_q [DEPTH];

  assign acc      = start && !busy_r;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == FULL_CNT);
  assign pos_ok   = CMP_W'(in_position) < CMP_W'(count_r);

  assign val64   = {{32{in_value_in[31]}}, in_value_in};
  assign val_w   = val64[WORD_BITS-1:0];
  assign rd_word = cell_q[IDX_W'(in_position)];
  assign rd64    = 64'(signed'(rd_word));

  always_comb begin
    ctrl       = '0;
    cell_pos   = CNT_W'(in_position);
    count_nxt  = count_r;
    status_nxt = sarr_pkg::ST_OK;
    rd_nxt     = '0;
    if (acc) begin
      unique case (sarr_pkg::func_t'(in_func))
        sarr_pkg::FN_INSERT: begin
          if (is_empty) begin
            ctrl.ins  = 1'b1;
            cell_pos  = '0;
            count_nxt = CNT_W'(1);
          end else if (is_full) begin
            status_nxt = sarr_pkg::ST_FULL;
          end else if (!pos_ok) begin
            status_nxt = sarr_pkg::ST_RANGE;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        sarr_pkg::FN_APPEND: begin
          if (is_full) begin
            status_nxt = sarr_pkg::ST_FULL;
          end else begin
            ctrl.app  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        sarr_pkg::FN_DELETE: begin
          if (is_empty) begin
            status_nxt = sarr_pkg::ST_EMPTY;
          end else if (!pos_ok) begin
            status_nxt = sarr_pkg::ST_RANGE;
          end else begin
            ctrl.del  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        sarr_pkg::FN_CLEAR: begin
          if (is_empty) begin
            status_nxt = sarr_pkg::ST_EMPTY;
          end
          count_nxt = '0;
        end
        sarr_pkg::FN_READ: begin
          if (is_empty) begin
            status_nxt = sarr_pkg::ST_EMPTY;
          end else if (!pos_ok) begin
            status_nxt = sarr_pkg::ST_RANGE;
          end else begin
            rd_nxt = rd64[31:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lo_d, hi_d;
    if (i == 0) begin : g_lo_edge
      assign lo_d = val_w;
    end else begin : g_lo
      assign lo_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_edge
      assign hi_d = cell_q[i];
    end else begin : g_hi
      assign hi_d = cell_q[i+1];
    end
    sarr_cell #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .pos   (cell_pos),
      .count (count_r),
      .lo_d  (lo_d),
      .hi_d  (hi_d),
      .val   (val_w),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      count_r     <= count_nxt;
      out_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= status_nxt;
      out_count_r  <= sarr_pkg::COUNT_BITS'(count_nxt);
      out_value_r  <= rd_nxt;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_count_out = out_count_r;
  assign out_value_out = out_value_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r) else $error("accepted word gave no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("fill count beyond depth");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r)) else $error("fill count moved without a word");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == sarr_pkg::ST_FULL) |-> is_full)
    else $error("full status with room left");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for shifting_array_insert_delete_core: a command driver,
// a result monitor and an in-bench array predictor, with directed then random words.
// Depends on sarr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import sarr_pkg::*;

  localparam int N_SLOTS  = DEPTH_DEF;
  localparam int N_RANDOM = 900;

  typedef struct {
    logic [2:0]                     func;
    logic [POS_BITS-1:0]            pos;
    logic signed [IN_WORD_BITS-1:0] val;
    int                             gap;
    bit                             drain;
  } cmd_t;

  typedef struct {
    status_t                        status;
    logic [COUNT_BITS-1:0]          count;
    logic signed [IN_WORD_BITS-1:0] value;
  } op_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [2:0]                     in_func = '0;
  logic [POS_BITS-1:0]            in_position = '0;
  logic signed [IN_WORD_BITS-1:0] in_value_in = '0;
  logic                           out_valid;
  logic [1:0]                     out_status;
  logic [COUNT_BITS-1:0]          out_count_out;
  logic signed [IN_WORD_BITS-1:0] out_value_out;

  cmd_t       cmd_q[$];
  op_result_t op_results_q[$];
  int         err_cnt = 0;
  int         idle_cnt = 0;
  int         gen_count = 0;
  bit         burst = 1'b0;

  // predictor state
  logic signed [IN_WORD_BITS-1:0] shadow_slots[N_SLOTS];
  int                             shadow_fill = 0;

  shifting_array_insert_delete_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_position   (in_position),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_count_out (out_count_out),
    .out_value_out (out_value_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  function automatic op_result_t apply_array_op(logic [2:0] f, logic [POS_BITS-1:0] p,
                                                logic signed [IN_WORD_BITS-1:0] v);
    op_result_t r;
    int         i;
    r.status = ST_OK;
    r.value  = '0;
    case (f)
      FN_INSERT: begin
        if (shadow_fill == 0) begin
          shadow_slots[0] = v;
          shadow_fill = 1;
        end else if (shadow_fill >= N_SLOTS) begin
          r.status = ST_FULL;
        end else if (int'(p) >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = shadow_fill; i > int'(p); i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[p] = v;
          shadow_fill++;
        end
      end
      FN_APPEND: begin
        if (shadow_fill >= N_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          shadow_slots[shadow_fill] = v;
          shadow_fill++;
        end
      end
      FN_DELETE: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(p) >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(p); i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_fill--;
        end
      end
      FN_CLEAR: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        shadow_fill = 0;
      end
      FN_READ: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else if (int'(p) >= shadow_fill) r.status = ST_RANGE;
        else r.value = shadow_slots[p];
      end
      default: ;
    endcase
    r.count = shadow_fill[COUNT_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [IN_WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // gen_count only steers positions towards valid indexes
  task automatic add_cmd(logic [2:0] f, int p, logic signed [IN_WORD_BITS-1:0] v,
                         bit drain = 1'b0);
    cmd_t c;
    c.func  = f;
    c.pos   = p[POS_BITS-1:0];
    c.val   = v;
    c.gap   = pick_gap();
    c.drain = drain;
    cmd_q.push_back(c);
    case (f)
      FN_INSERT: begin
        if (gen_count == 0) gen_count = 1;
        else if (gen_count < N_SLOTS && p < gen_count) gen_count++;
      end
      FN_APPEND: if (gen_count < N_SLOTS) gen_count++;
      FN_DELETE: if (gen_count > 0 && p < gen_count) gen_count--;
      FN_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic nxt_start;
    cmd_t c;
    if (!rst_n) begin
      start <= 1'b0;
      idle_cnt = 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        op_results_q.push_back(apply_array_op(in_func, in_position, in_value_in));
        nxt_start = 1'b0;
      end
      if (!nxt_start && cmd_q.size() != 0) begin
        c = cmd_q[0];
        if (c.drain && op_results_q.size() != 0) begin
          idle_cnt = 0;
        end else if (idle_cnt < c.gap) begin
          idle_cnt++;
        end else begin
          void'(cmd_q.pop_front());
          idle_cnt = 0;
          in_func     <= c.func;
          in_position <= c.pos;
          in_value_in <= c.val;
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    op_result_t e;
    if (rst_n && out_valid !== 1'b0) begin
      if (op_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word: status %0d count %0d value %0d",
                                  out_status, out_count_out, out_value_out));
      end else begin
        e = op_results_q.pop_front();
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
        if (out_count_out !== e.count)
          report_mismatch($sformatf("count %0d, want %0d", out_count_out, e.count));
        if (out_value_out !== e.value)
          report_mismatch($sformatf("value %0d, want %0d", out_value_out, e.value));
      end
    end
  end

  initial begin : stim
    int               n;
    int               r;
    int               p;
    logic [2:0]       f;
    bit               filling;
    logic signed [31:0] w;

    // empty array cases, then insert into empty with a stray index
    add_cmd(FN_READ, 0, 0);
    add_cmd(FN_DELETE, 3, 0);
    add_cmd(FN_CLEAR, 0, 0);
    add_cmd(FN_INSERT, 15, 32'sh8000_0000);
    for (n = 0; n < N_SLOTS - 1; n++) begin
      case (n)
        0:       w = 32'sh7fff_ffff;
        1:       w = -1;
        2:       w = '0;
        3:       w = 32'sh5555_5555;
        4:       w = 32'shaaaa_aaaa;
        default: w = pick_word();
      endcase
      add_cmd(FN_APPEND, n, w);
    end
    // full array: append and insert at the last index report full
    add_cmd(FN_APPEND, 0, 1);
    add_cmd(FN_INSERT, 15, 1);
    add_cmd(FN_READ, 15, 0);
    add_cmd(FN_READ, 0, 0);
    add_cmd(FN_DELETE, 15, 0);
    add_cmd(FN_INSERT, 15, 2);
    add_cmd(FN_DELETE, 15, 0);
    add_cmd(FN_READ, 15, 0);
    add_cmd(FN_INSERT, 0, 32'sh7fff_ffff);
    add_cmd(FN_DELETE, 0, 0);
    for (n = 5; n <= 7; n++) add_cmd(n[2:0], 15, -1);
    add_cmd(FN_CLEAR, 0, 0, 1'b1);

    filling = 1'b1;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 60 == 0) begin
        filling = $urandom_range(0, 1);
        burst   = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 35)      f = FN_INSERT;
        else if (r < 65) f = FN_APPEND;
        else if (r < 75) f = FN_DELETE;
        else if (r < 93) f = FN_READ;
        else if (r < 96) f = FN_CLEAR;
        else             f = 3'($urandom_range(5, 7));
      end else begin
        if (r < 12)      f = FN_INSERT;
        else if (r < 22) f = FN_APPEND;
        else if (r < 70) f = FN_DELETE;
        else if (r < 93) f = FN_READ;
        else if (r < 96) f = FN_CLEAR;
        else             f = 3'($urandom_range(5, 7));
      end
      if (gen_count > 0 && $urandom_range(0, 9) != 0) p = $urandom_range(0, gen_count - 1);
      else p = $urandom_range(0, 15);
      add_cmd(f, p, pick_word(), (n % 150 == 149));
    end

    while (cmd_q.size() != 0 || start || op_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
